>>> rtl/request_completion_ring_queues_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the request/completion ring queues
// Each macro expects clk and arst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef REQUEST_COMPLETION_RING_QUEUES_DEFINES_SVH
`define REQUEST_COMPLETION_RING_QUEUES_DEFINES_SVH

// same-cycle implication
`define RCRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RCRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rcrq_pkg.sv
// ---------------------------------------------------------------------------
// rcrq_pkg
// Operation codes, the command passed from front to back, back state codes.
// ---------------------------------------------------------------------------
`default_nettype none

package rcrq_pkg;

	typedef enum logic [2:0] {
		OP_PUSH_REQ = 3'd0,
		OP_POP_REQ  = 3'd1,
		OP_PUSH_CPL = 3'd2,
		OP_POP_CPL  = 3'd3,
		OP_FLUSH    = 3'd4,
		OP_NOP      = 3'd7
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] data;
		logic [31:0] tag;
	} cmd_t;

	typedef enum logic {
		BK_RUN      = 1'b0,
		BK_POP_WAIT = 1'b1
	} bk_state_t;

	localparam int unsigned CMDQ_DEPTH = 2;

endpackage

`default_nettype wire

>>> rtl/rcrq_front.sv
// ---------------------------------------------------------------------------
// rcrq_front
// Accepts input transactions, decodes the operation and holds them in a
// two-entry command queue in front of the execution back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rcrq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    req_type,
	input  wire logic [31:0]   data_in,
	input  wire logic [31:0]   generation_tag,
	output logic               cmd_valid,
	input  wire logic          cmd_stall,
	output rcrq_pkg::cmd_t     cmd
);

	rcrq_pkg::cmd_t slot_q [rcrq_pkg::CMDQ_DEPTH];
	logic           wr_idx_q;
	logic           rd_idx_q;
	logic [1:0]     cnt_q;
	rcrq_pkg::cmd_t dec;
	logic           push;
	logic           pop;

	always_comb begin
		dec.data = data_in;
		dec.tag  = generation_tag;
		unique case (req_type)
			rcrq_pkg::OP_PUSH_REQ: dec.op = rcrq_pkg::OP_PUSH_REQ;
			rcrq_pkg::OP_POP_REQ:  dec.op = rcrq_pkg::OP_POP_REQ;
			rcrq_pkg::OP_PUSH_CPL: dec.op = rcrq_pkg::OP_PUSH_CPL;
			rcrq_pkg::OP_POP_CPL:  dec.op = rcrq_pkg::OP_POP_CPL;
			rcrq_pkg::OP_FLUSH:    dec.op = rcrq_pkg::OP_FLUSH;
			default:               dec.op = rcrq_pkg::OP_NOP;
		endcase
	end

	assign in_stall  = (cnt_q == 2'(rcrq_pkg::CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_idx_q];
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_idx_q <= ~wr_idx_q;
			if (pop)  rd_idx_q <= ~rd_idx_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_idx_q] <= dec;
	end

endmodule

`default_nettype wire

>>> rtl/rcrq_back.sv
// ---------------------------------------------------------------------------
// rcrq_back
// Executes queued commands against the two rings: pointers, drop counters,
// active generation, the two payload memories and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "request_completion_ring_queues_defines.svh"

module rcrq_back #(
	parameter int unsigned QUEUE_SIZE = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire rcrq_pkg::cmd_t cmd,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               ok,
	output logic [31:0]        data_out,
	output logic [31:0]        tag_out,
	output logic [5:0]         req_level,
	output logic [5:0]         cpl_level,
	output logic [31:0]        request_drops,
	output logic [31:0]        completion_drops
);

	localparam int unsigned PW = $clog2(QUEUE_SIZE);
	localparam int unsigned SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int unsigned EW = (PW + 1 > 6) ? PW + 1 : 6;
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_SIZE - 1);
	localparam logic [PW:0]   RING_SZ  = (PW + 1)'(QUEUE_SIZE);
	localparam logic [PW:0]   MAX_FILL = (PW + 1)'(QUEUE_SIZE - 1);

	logic [SW-1:0] req_mem [QUEUE_SIZE];
	logic [SW-1:0] cpl_mem [QUEUE_SIZE];
	logic [SW-1:0] req_rd_q;
	logic [SW-1:0] cpl_rd_q;

	logic [PW-1:0] rw_q, rr_q, cw_q, cr_q;
	logic [PW-1:0] nx_rw, nx_rr, nx_cw, nx_cr;
	logic [31:0]   gen_q, nx_gen;
	logic [31:0]   rdrop_q, nx_rdrop;
	logic [31:0]   cdrop_q, nx_cdrop;

	rcrq_pkg::bk_state_t state_q, nx_state;
	logic pop_cpl_q, nx_pop_cpl;
	logic out_valid_q;
	logic out_free;
	logic take;
	logic req_we, cpl_we, req_re, cpl_re;
	logic imm_load, imm_ok;

	function automatic logic [PW:0] ring_count(input logic [PW-1:0] w, input logic [PW-1:0] r);
		logic [PW:0] we;
		logic [PW:0] re;
		we = {1'b0, w};
		re = {1'b0, r};
		return (w >= r) ? (we - re) : (we + RING_SZ - re);
	endfunction

	function automatic logic [5:0] depth6(input logic [PW-1:0] w, input logic [PW-1:0] r);
		logic [EW-1:0] e;
		e = EW'(ring_count(w, r));
		return e[5:0];
	endfunction

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PW'(1);
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign cmd_stall = !((state_q == rcrq_pkg::BK_RUN) && out_free);
	assign take      = cmd_valid && !cmd_stall;

	always_comb begin
		nx_rw      = rw_q;
		nx_rr      = rr_q;
		nx_cw      = cw_q;
		nx_cr      = cr_q;
		nx_gen     = gen_q;
		nx_rdrop   = rdrop_q;
		nx_cdrop   = cdrop_q;
		nx_state   = state_q;
		nx_pop_cpl = pop_cpl_q;
		req_we     = 1'b0;
		cpl_we     = 1'b0;
		req_re     = 1'b0;
		cpl_re     = 1'b0;
		imm_load   = 1'b0;
		imm_ok     = 1'b0;
		unique case (state_q)
			rcrq_pkg::BK_RUN: begin
				if (take) begin
					imm_load = 1'b1;
					unique case (cmd.op)
						rcrq_pkg::OP_PUSH_REQ: begin
							if (ring_count(rw_q, rr_q) >= MAX_FILL) begin
								nx_rdrop = rdrop_q + 32'd1;
							end else begin
								req_we = 1'b1;
								nx_rw  = ring_next(rw_q);
								imm_ok = 1'b1;
							end
						end
						rcrq_pkg::OP_POP_REQ: begin
							if (rw_q != rr_q) begin
								// result comes from the registered memory read
								req_re     = 1'b1;
								nx_rr      = ring_next(rr_q);
								nx_pop_cpl = 1'b0;
								nx_state   = rcrq_pkg::BK_POP_WAIT;
								imm_load   = 1'b0;
							end
						end
						rcrq_pkg::OP_PUSH_CPL: begin
							// stale generation drops before the fullness check
							if (cmd.tag != gen_q || ring_count(cw_q, cr_q) >= MAX_FILL) begin
								nx_cdrop = cdrop_q + 32'd1;
							end else begin
								cpl_we = 1'b1;
								nx_cw  = ring_next(cw_q);
								imm_ok = 1'b1;
							end
						end
						rcrq_pkg::OP_POP_CPL: begin
							if (cw_q != cr_q) begin
								cpl_re     = 1'b1;
								nx_cr      = ring_next(cr_q);
								nx_pop_cpl = 1'b1;
								nx_state   = rcrq_pkg::BK_POP_WAIT;
								imm_load   = 1'b0;
							end
						end
						rcrq_pkg::OP_FLUSH: begin
							nx_rw  = '0;
							nx_rr  = '0;
							nx_cw  = '0;
							nx_cr  = '0;
							nx_gen = cmd.tag;
							imm_ok = 1'b1;
						end
						default: begin
							imm_ok = 1'b0;
						end
					endcase
				end
			end
			rcrq_pkg::BK_POP_WAIT: begin
				nx_state = rcrq_pkg::BK_RUN;
			end
			default: begin
				nx_state = rcrq_pkg::BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rcrq_pkg::BK_RUN;
			pop_cpl_q   <= 1'b0;
			rw_q        <= '0;
			rr_q        <= '0;
			cw_q        <= '0;
			cr_q        <= '0;
			gen_q       <= '0;
			rdrop_q     <= '0;
			cdrop_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= nx_state;
			pop_cpl_q <= nx_pop_cpl;
			rw_q      <= nx_rw;
			rr_q      <= nx_rr;
			cw_q      <= nx_cw;
			cr_q      <= nx_cr;
			gen_q     <= nx_gen;
			rdrop_q   <= nx_rdrop;
			cdrop_q   <= nx_cdrop;
			if (imm_load || state_q == rcrq_pkg::BK_POP_WAIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_we) req_mem[rw_q] <= cmd.data[SW-1:0];
		if (req_re) req_rd_q <= req_mem[rr_q];
	end

	always_ff @(posedge clk) begin
		if (cpl_we) cpl_mem[cw_q] <= cmd.data[SW-1:0];
		if (cpl_re) cpl_rd_q <= cpl_mem[cr_q];
	end

	// Every queued completion carries the active generation: pushes with any
	// other tag are dropped and a generation change empties the ring.
	always_ff @(posedge clk) begin
		if (imm_load) begin
			ok               <= imm_ok;
			data_out         <= '0;
			tag_out          <= '0;
			req_level        <= depth6(nx_rw, nx_rr);
			cpl_level        <= depth6(nx_cw, nx_cr);
			request_drops    <= nx_rdrop;
			completion_drops <= nx_cdrop;
		end else if (state_q == rcrq_pkg::BK_POP_WAIT) begin
			ok               <= 1'b1;
			data_out         <= pop_cpl_q ? 32'(cpl_rd_q) : 32'(req_rd_q);
			tag_out          <= pop_cpl_q ? gen_q : 32'd0;
			req_level        <= depth6(rw_q, rr_q);
			cpl_level        <= depth6(cw_q, cr_q);
			request_drops    <= rdrop_q;
			completion_drops <= cdrop_q;
		end
	end

	assign out_valid = out_valid_q;

	`RCRQ_ASSERT_NOW(a_wait_out_empty, state_q == rcrq_pkg::BK_POP_WAIT, !out_valid_q, "pop wait with result pending")
	`RCRQ_ASSERT_NEXT(a_wait_delivers, state_q == rcrq_pkg::BK_POP_WAIT, out_valid_q && state_q == rcrq_pkg::BK_RUN, "pop wait did not load result")
	`RCRQ_ASSERT_NOW(a_ptr_range, 1'b1, rw_q <= LAST_PTR && rr_q <= LAST_PTR && cw_q <= LAST_PTR && cr_q <= LAST_PTR, "ring pointer out of range")
	`RCRQ_ASSERT_NEXT(a_flush_empties, take && cmd.op == rcrq_pkg::OP_FLUSH, rw_q == rr_q && cw_q == cr_q, "flush left entries")

endmodule

`default_nettype wire

>>> rtl/request_completion_ring_queues.sv
// Command queue, then result register; a pop returning an entry adds the memory read register.
// Throughput: 1 transaction per cycle for push, flush, rejected and empty-pop operations
// while out_stall is low; a pop returning an entry holds the back end for the registered memory read.
// A 2-entry command queue lets inputs keep arriving while a result waits on out_stall.
// Reset (arst_n low): pointers, generation, drop counts and queues clear at once; no sweep.
// ---------------------------------------------------------------------------
// request_completion_ring_queues
// Request ring and generation-tagged completion ring with drop accounting.
// ---------------------------------------------------------------------------
`default_nettype none

module request_completion_ring_queues #(
	parameter int unsigned QUEUE_SIZE = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    req_type,
	input  wire logic [31:0]   data_in,
	input  wire logic [31:0]   generation_tag,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic               ok,
	output logic [31:0]        data_out,
	output logic [31:0]        tag_out,
	output logic [5:0]         req_level,
	output logic [5:0]         cpl_level,
	output logic [31:0]        request_drops,
	output logic [31:0]        completion_drops
);

	rcrq_pkg::cmd_t cmd;
	logic           cmd_valid;
	logic           cmd_stall;

	rcrq_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.data_in        (data_in),
		.generation_tag (generation_tag),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.cmd            (cmd)
	);

	rcrq_back #(
		.QUEUE_SIZE (QUEUE_SIZE),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (cmd_valid),
		.cmd_stall        (cmd_stall),
		.cmd              (cmd),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.ok               (ok),
		.data_out         (data_out),
		.tag_out          (tag_out),
		.req_level        (req_level),
		.cpl_level        (cpl_level),
		.request_drops    (request_drops),
		.completion_drops (completion_drops)
	);

endmodule

`default_nettype wire
